[hw/rtl/next_prime_trial_division_unit_defines.svh]
// Assertion macros for the next-prime trial division unit.
// Included by the top level; no other dependencies.
`ifndef NEXT_PRIME_TRIAL_DIVISION_UNIT_DEFINES_SVH
`define NEXT_PRIME_TRIAL_DIVISION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define NPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npt assertion failed");

`define NPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npt assertion failed");

`else

`define NPT_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define NPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/npt_pkg.sv]
// Shared widths, microcode control word type and program ROM for the
// next-prime trial division unit. No dependencies.
package npt_pkg;

    localparam int VALUE_W = 32;
    localparam int DIV_W   = VALUE_W / 2 + 1;
    localparam int SQ_W    = 2 * DIV_W;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int PC_W    = 4;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_IN    = 3'd2,
        C_DIV_BUSY = 3'd3,
        C_REM_ZERO = 3'd4,
        C_SQ_GE    = 3'd5,
        C_TOP      = 3'd6,
        C_OUT_BUSY = 3'd7
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        logic  load_d3;
        logic  div_start;
        logic  div_step;
        logic  add_d2;
        logic  do_sq;
        logic  cand_add2;
        logic  set_ovf;
        logic  out_load;
        logic  fin;
        t_cond cond;
        t_pc   target;
    } t_uword;

    localparam t_pc STEP_IDLE = t_pc'(0);
    localparam t_pc STEP_D3   = t_pc'(1);
    localparam t_pc STEP_DIV  = t_pc'(2);
    localparam t_pc STEP_REM  = t_pc'(3);
    localparam t_pc STEP_SQ   = t_pc'(4);
    localparam t_pc STEP_BND  = t_pc'(5);
    localparam t_pc STEP_NXT  = t_pc'(6);
    localparam t_pc STEP_FAIL = t_pc'(7);
    localparam t_pc STEP_ADV  = t_pc'(8);
    localparam t_pc STEP_OVF  = t_pc'(9);
    localparam t_pc STEP_OUT  = t_pc'(10);

    function automatic t_uword npt_rom(input t_pc pc);
        t_uword w;
        w        = '0;
        w.cond   = C_NEVER;
        w.target = STEP_IDLE;
        case (pc)
            STEP_IDLE: begin
                w.in_ready = 1'b1;
                w.cond     = C_NO_IN;
                w.target   = STEP_IDLE;
            end
            STEP_D3: begin
                w.load_d3   = 1'b1;
                w.div_start = 1'b1;
            end
            STEP_DIV: begin
                w.div_step = 1'b1;
                w.cond     = C_DIV_BUSY;
                w.target   = STEP_DIV;
            end
            STEP_REM: begin
                w.add_d2 = 1'b1;
                w.cond   = C_REM_ZERO;
                w.target = STEP_FAIL;
            end
            STEP_SQ: begin
                w.do_sq = 1'b1;
            end
            STEP_BND: begin
                w.cond   = C_SQ_GE;
                w.target = STEP_OUT;
            end
            STEP_NXT: begin
                w.div_start = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = STEP_DIV;
            end
            STEP_FAIL: begin
                w.cond   = C_TOP;
                w.target = STEP_OVF;
            end
            STEP_ADV: begin
                w.cand_add2 = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = STEP_D3;
            end
            STEP_OVF: begin
                w.set_ovf = 1'b1;
            end
            STEP_OUT: begin
                w.out_load = 1'b1;
                w.fin      = 1'b1;
                w.cond     = C_OUT_BUSY;
                w.target   = STEP_OUT;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/npt_in_if.sv]
// Input channel of the next-prime unit: valid/ready plus the start value.
// Depends on npt_pkg.
interface npt_in_if;
    import npt_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] start_value;

    modport source (output valid, output start_value, input ready);
    modport sink (input valid, input start_value, output ready);
endinterface

[hw/rtl/npt_out_if.sv]
// Result channel of the next-prime unit: valid/ready, prime and overflow.
// Depends on npt_pkg.
interface npt_out_if;
    import npt_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] prime_found;
    logic               overflow;

    modport source (output valid, output prime_found, output overflow, input ready);
    modport sink (input valid, input prime_found, input overflow, output ready);
endinterface

[hw/rtl/next_prime_trial_division_unit.sv]
// Next-prime search by trial division, run by a microcoded sequencer.
// Per candidate: the test by 3, then one test per odd divisor up to the ceiling
// square root, each a division in the radix-2 restoring divider.
// One item is in work at a time.
// The result waits in an output register; the next beat is taken meanwhile.
// Synchronous active-low reset returns the sequencer to idle and empties the output.
`include "next_prime_trial_division_unit_defines.svh"

module next_prime_trial_division_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    npt_in_if.sink    i_in,
    npt_out_if.source o_out
);
    import npt_pkg::*;

    localparam logic [VALUE_W-1:0] CAND_TOP  = {{(VALUE_W - 2){1'b1}}, 2'b01};
    localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(VALUE_W - 1);
    localparam logic [DIV_W-1:0]   DIVISOR_3 = DIV_W'(3);

    t_pc                r_pc;
    t_pc                n_pc;
    t_uword             w_uw;
    logic               w_cond;
    logic               w_in_acc;
    logic               w_out_free;

    logic [VALUE_W-1:0] r_cand;
    logic               r_ovf;
    logic [DIV_W-1:0]   r_div;
    logic [DIV_W-1:0]   r_rem;
    logic [VALUE_W-1:0] r_dvd;
    logic [CNT_W-1:0]   r_cnt;
    logic [SQ_W-1:0]    r_sq;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_prime;
    logic               r_out_ovf;

    logic [DIV_W:0]     w_trial;
    logic               w_trial_ge;
    logic [DIV_W:0]     w_trial_rem;
    logic [DIV_W-1:0]   w_dm1;
    logic [SQ_W-1:0]    w_sq;

    assign w_uw       = npt_rom(r_pc);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_acc   = w_uw.in_ready && i_in.valid;

    assign i_in.ready        = w_uw.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.prime_found = r_out_prime;
    assign o_out.overflow    = r_out_ovf;

    assign w_trial     = {r_rem, r_dvd[VALUE_W-1]};
    assign w_trial_ge  = w_trial >= {1'b0, r_div};
    assign w_trial_rem = w_trial_ge ? (w_trial - {1'b0, r_div}) : w_trial;
    assign w_dm1       = r_div - DIV_W'(1);
    assign w_sq        = {{DIV_W{1'b0}}, w_dm1} * {{DIV_W{1'b0}}, w_dm1};

    always_comb begin
        case (w_uw.cond)
            C_NEVER:    w_cond = 1'b0;
            C_ALWAYS:   w_cond = 1'b1;
            C_NO_IN:    w_cond = !i_in.valid;
            C_DIV_BUSY: w_cond = r_cnt != CNT_LAST;
            C_REM_ZERO: w_cond = r_rem == '0;
            C_SQ_GE:    w_cond = r_sq >= {{(SQ_W - VALUE_W){1'b0}}, r_cand};
            C_TOP:      w_cond = r_cand > CAND_TOP;
            C_OUT_BUSY: w_cond = !w_out_free;
            default:    w_cond = 1'b0;
        endcase
    end

    always_comb begin
        if (w_cond) begin
            n_pc = w_uw.target;
        end else if (w_uw.fin) begin
            n_pc = STEP_IDLE;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_uw.out_load && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cand <= i_in.start_value | VALUE_W'(1);
            r_ovf  <= 1'b0;
        end else if (w_uw.cand_add2) begin
            r_cand <= r_cand + VALUE_W'(2);
        end else if (w_uw.set_ovf) begin
            r_cand <= '0;
            r_ovf  <= 1'b1;
        end
        if (w_uw.load_d3) begin
            r_div <= DIVISOR_3;
        end else if (w_uw.add_d2) begin
            r_div <= r_div + DIV_W'(2);
        end
        if (w_uw.div_start) begin
            r_rem <= '0;
            r_dvd <= r_cand;
            r_cnt <= '0;
        end else if (w_uw.div_step) begin
            r_rem <= w_trial_rem[DIV_W-1:0];
            r_dvd <= {r_dvd[VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (w_uw.do_sq) begin
            r_sq <= w_sq;
        end
        if (w_uw.out_load && w_out_free) begin
            r_out_prime <= r_cand;
            r_out_ovf   <= r_ovf;
        end
    end

    `NPT_ASSERT_NEXT(a_accept_starts_test, i_clk, i_rst_n,
        i_in.valid && i_in.ready, r_pc == STEP_D3)
    `NPT_ASSERT_SAME(a_rem_below_divisor, i_clk, i_rst_n,
        r_pc == STEP_DIV, r_rem < r_div)
    `NPT_ASSERT_SAME(a_ovf_zero_prime, i_clk, i_rst_n,
        o_out.valid && o_out.overflow, o_out.prime_found == '0)
    `NPT_ASSERT_SAME(a_prime_is_odd, i_clk, i_rst_n,
        o_out.valid && !o_out.overflow, o_out.prime_found[0])

endmodule
